// ===== sv/rtks_pkg.sv =====
`default_nettype none
package rtks_pkg;

  localparam int VECTOR_DEPTH = 4096;
  localparam int MAX_KEEP     = 64;

  localparam int ADDR_W      = $clog2(VECTOR_DEPTH);
  localparam int KEEP_W      = $clog2(MAX_KEEP + 1);
  localparam int SLOT_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int DATA_W      = 32;
  localparam int OUT_INDEX_W = 12;
  localparam int CFG_W       = 7;
  localparam int PADDR_W     = 2;
  localparam int PDATA_W     = 32;

  localparam logic [CFG_W-1:0]   KEEP_RESET     = 7'd8;
  localparam logic [PADDR_W-1:0] REG_KEEP_COUNT = 2'd0;

  typedef struct packed {
    logic take;
    logic clear;
    logic read;
    logic update;
    logic insert;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last_item;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/residual_topk_sparsifier.sv =====
`default_nettype none
// Residual top-K sparsifier. Elements of a vector arrive one per request on
// the in_ channel; each is added, with 32-bit signed saturation, into the
// residual entry at its position, and the updated residual is offered to a
// sorted list of the 64 largest magnitudes (ties keep the lower position
// first). The request carrying in_last_element releases min(K, elements seen)
// (position, residual) pairs on the out_ channel, largest magnitude first,
// with out_last_entry on the final pair; residuals persist across vectors.
// K is keep_count at byte address 0 (reset 8, 0 acts as 1, above 64 acts as
// 64); write it only while the block is idle. Sequence: after reset the block
// clears its 4096-entry residual memory, one entry a cycle, and holds
// in_stall high until the clearing is done. Each element then passes through
// accept, memory read, saturating add with write-back and list insertion
// before the next is taken, the read-modify-write on the single-port residual
// memory being followed by the parallel list insertion. A last element then
// releases one pair a cycle while the output register is not stalled.
module residual_topk_sparsifier (
  input  wire                                clk,
  input  wire                                rst_n,
  // element channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire signed [rtks_pkg::DATA_W-1:0]  in_sample_value,
  input  wire                                in_last_element,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [rtks_pkg::OUT_INDEX_W-1:0]   out_entry_index,
  output logic signed [rtks_pkg::DATA_W-1:0] out_entry_value,
  output logic                               out_last_entry,
  // configuration port
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [rtks_pkg::PADDR_W-1:0]        cfg_paddr,
  input  wire [rtks_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [rtks_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                               cfg_pready
);

  rtks_pkg::cmd_t  cmd;
  rtks_pkg::stat_t stat;

  logic [rtks_pkg::CFG_W-1:0] keep_count_r;
  logic                       cfg_wr;

  // no wait states on the register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= rtks_pkg::KEEP_RESET;
    end else if (cfg_wr && (cfg_paddr == rtks_pkg::REG_KEEP_COUNT)) begin
      keep_count_r <= cfg_pwdata[rtks_pkg::CFG_W-1:0];
    end
  end

  // readback of the stored value, unknown addresses read zero
  always_comb begin
    if (cfg_paddr == rtks_pkg::REG_KEEP_COUNT) begin
      cfg_prdata = rtks_pkg::PDATA_W'(keep_count_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // sequencer: clearing pass, per-element read/add/insert, pair emission
  rtks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // residual memory, sorted candidate list and output register
  rtks_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .keep_count      (keep_count_r),
    .in_sample_value (in_sample_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry)
  );

endmodule
`default_nettype wire

// ===== sv/rtks_ctrl.sv =====
`default_nettype none
module rtks_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire rtks_pkg::stat_t stat,
  output rtks_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_INSERT,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (stat.clear_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_INSERT;
      S_INSERT: state_nxt = stat.last_item ? S_EMIT : S_IDLE;
      S_EMIT:   if (stat.out_free && stat.emit_last) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.take   = (state_r == S_IDLE) && in_valid;
    cmd.clear  = (state_r == S_CLEAR);
    cmd.read   = (state_r == S_READ);
    cmd.update = (state_r == S_UPDATE);
    cmd.insert = (state_r == S_INSERT);
    cmd.load   = (state_r == S_EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtks_dpath.sv =====
`default_nettype none
module rtks_dpath (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire rtks_pkg::cmd_t                   cmd,
  output rtks_pkg::stat_t                       stat,
  input  wire [rtks_pkg::CFG_W-1:0]             keep_count,
  input  wire signed [rtks_pkg::DATA_W-1:0]     in_sample_value,
  input  wire                                   in_last_element,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [rtks_pkg::OUT_INDEX_W-1:0]      out_entry_index,
  output logic signed [rtks_pkg::DATA_W-1:0]    out_entry_value,
  output logic                                  out_last_entry
);

  localparam int AW = rtks_pkg::ADDR_W;
  localparam int DW = rtks_pkg::DATA_W;
  localparam int KW = rtks_pkg::KEEP_W;
  localparam int SW = rtks_pkg::SLOT_W;
  localparam int NK = rtks_pkg::MAX_KEEP;

  // residual memory
  logic signed [DW-1:0] mem [rtks_pkg::VECTOR_DEPTH];
  logic signed [DW-1:0] rd_data_r;
  logic [AW-1:0]        clr_addr_r;
  logic [AW-1:0]        cnt_r;

  logic signed [DW-1:0] sample_r;
  logic                 last_r;
  logic signed [DW-1:0] sum_r;
  logic signed [DW:0]   sum_wide;
  logic signed [DW-1:0] sum_sat;
  logic [DW-1:0]        new_mag;

  // candidate list, kept sorted by descending magnitude
  logic [AW-1:0]        idx_r [NK];
  logic signed [DW-1:0] val_r [NK];
  logic [DW-1:0]        mag_r [NK];
  logic [AW-1:0]        idx_nxt [NK];
  logic signed [DW-1:0] val_nxt [NK];
  logic [DW-1:0]        mag_nxt [NK];
  logic [NK-1:0]        ge;
  logic [KW-1:0]        fill_r;

  logic [SW-1:0]        emit_idx_r;
  logic [KW-1:0]        keep_eff;
  logic [KW-1:0]        emit_n;
  logic                 emit_last;
  logic                 out_valid_r;
  logic                 out_free;

  assign sum_wide = {rd_data_r[DW-1], rd_data_r} + {sample_r[DW-1], sample_r};

  always_comb begin
    if (sum_wide[DW] != sum_wide[DW-1]) begin
      sum_sat = sum_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[DW-1:0];
    end
  end

  assign new_mag = sum_r[DW-1] ? (~sum_r + DW'(1)) : sum_r;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.update) begin
      mem[cnt_r] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data_r <= mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r <= in_sample_value;
      last_r   <= in_last_element;
    end
    if (cmd.update) begin
      sum_r <= sum_sat;
    end
  end

  always_comb begin
    for (int i = 0; i < NK; i++) begin
      ge[i] = (KW'(i) < fill_r) && (mag_r[i] >= new_mag);
    end
    if (ge[0]) begin
      idx_nxt[0] = idx_r[0];
      val_nxt[0] = val_r[0];
      mag_nxt[0] = mag_r[0];
    end else begin
      idx_nxt[0] = cnt_r;
      val_nxt[0] = sum_r;
      mag_nxt[0] = new_mag;
    end
    for (int i = 1; i < NK; i++) begin
      if (ge[i]) begin
        idx_nxt[i] = idx_r[i];
        val_nxt[i] = val_r[i];
        mag_nxt[i] = mag_r[i];
      end else if (ge[i-1]) begin
        idx_nxt[i] = cnt_r;
        val_nxt[i] = sum_r;
        mag_nxt[i] = new_mag;
      end else begin
        idx_nxt[i] = idx_r[i-1];
        val_nxt[i] = val_r[i-1];
        mag_nxt[i] = mag_r[i-1];
      end
    end
  end

  // insertion shifts the tail down, emission shifts the head out of slot 0
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < NK; i++) begin
        idx_r[i] <= idx_nxt[i];
        val_r[i] <= val_nxt[i];
        mag_r[i] <= mag_nxt[i];
      end
    end else if (cmd.load) begin
      for (int i = 0; i < NK - 1; i++) begin
        idx_r[i] <= idx_r[i+1];
        val_r[i] <= val_r[i+1];
      end
    end
  end

  // k clamped to 1..MAX_KEEP, then limited by the list fill
  always_comb begin
    if (keep_count == '0) begin
      keep_eff = KW'(1);
    end else if (keep_count > rtks_pkg::CFG_W'(NK)) begin
      keep_eff = KW'(NK);
    end else begin
      keep_eff = KW'(keep_count);
    end
    emit_n = (fill_r < keep_eff) ? fill_r : keep_eff;
  end

  assign emit_last = (KW'(emit_idx_r) + KW'(1)) == emit_n;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      fill_r      <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.insert) begin
        if (fill_r < KW'(NK)) begin
          fill_r <= fill_r + KW'(1);
        end
        if (!last_r) begin
          cnt_r <= (cnt_r == AW'(rtks_pkg::VECTOR_DEPTH - 1)) ? '0 : cnt_r + AW'(1);
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
        if (emit_last) begin
          emit_idx_r <= '0;
          fill_r     <= '0;
          cnt_r      <= '0;
        end else begin
          emit_idx_r <= emit_idx_r + SW'(1);
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_entry_index <= rtks_pkg::OUT_INDEX_W'(idx_r[0]);
      out_entry_value <= val_r[0];
      out_last_entry  <= emit_last;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat            = '0;
    stat.clear_done = (clr_addr_r == AW'(rtks_pkg::VECTOR_DEPTH - 1));
    stat.last_item  = last_r;
    stat.emit_last  = emit_last;
    stat.out_free   = out_free;
  end

endmodule
`default_nettype wire

// ===== sv/rtks_checker.sv =====
`default_nettype none
module rtks_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire [rtks_pkg::OUT_INDEX_W-1:0]    out_entry_index,
  input wire signed [rtks_pkg::DATA_W-1:0]  out_entry_value,
  input wire                                out_last_entry
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_index) &&
      $stable(out_entry_value) && $stable(out_last_entry))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted element keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("element accepted back to back");

  // a non-final pair pending means emission is still in progress
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_entry |-> in_stall)
    else $error("element accepted in the middle of a result run");

endmodule

bind residual_topk_sparsifier rtks_checker u_chk (.*);
`default_nettype wire

// ===== tb/residual_topk_sparsifier_tb.sv =====
module residual_topk_sparsifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W       = rtks_pkg::DATA_W;
  localparam int OUT_INDEX_W  = rtks_pkg::OUT_INDEX_W;
  localparam int PADDR_W      = rtks_pkg::PADDR_W;
  localparam int PDATA_W      = rtks_pkg::PDATA_W;
  localparam int VECTOR_DEPTH = rtks_pkg::VECTOR_DEPTH;
  localparam int ADDR_W       = rtks_pkg::ADDR_W;
  localparam int MAX_KEEP     = rtks_pkg::MAX_KEEP;
  localparam int CFG_W        = rtks_pkg::CFG_W;
  localparam logic [CFG_W-1:0]   KEEP_RESET     = rtks_pkg::KEEP_RESET;
  localparam logic [PADDR_W-1:0] REG_KEEP_COUNT = rtks_pkg::REG_KEEP_COUNT;

  // generous bound: clearing pass plus every request and pair under heavy stalls
  localparam int CYCLE_LIMIT = 400000;
  // cycles the block may still be busy after its last visible result
  localparam int DRAIN_CYCLES = 8;
  localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // one element request as queued for the driver
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     wait_drain;  // hold until all pairs are back
  } element_t;

  // one (position, residual) pair as the block should emit it
  typedef struct {
    logic [OUT_INDEX_W-1:0]   index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } pair_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [DATA_W-1:0]    in_sample_value = '0;
  logic                        in_last_element = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [OUT_INDEX_W-1:0]      out_entry_index;
  logic signed [DATA_W-1:0]    out_entry_value;
  logic                        out_last_entry;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]          cfg_paddr = '0;
  logic [PDATA_W-1:0]          cfg_pwdata = '0;
  logic [PDATA_W-1:0]          cfg_prdata;
  logic                        cfg_pready;

  // shadow of the block: residual memory, ranked candidate list, K
  logic signed [DATA_W-1:0]    residual_mirror [VECTOR_DEPTH];
  logic [ADDR_W-1:0]           next_slot;
  logic [ADDR_W-1:0]           ranked_pos [MAX_KEEP];
  logic signed [DATA_W-1:0]    ranked_val [MAX_KEEP];
  int                          ranked_count;
  logic [CFG_W-1:0]            keep_setting;

  element_t                    element_queue [$];
  pair_t                       pending_pairs [$];
  element_t                    on_wire;
  logic                        steady = 1'b0;   // no idling on either side

  int                          cycle_count = 0;
  int                          fail_count = 0;
  int                          elements_taken = 0;
  int                          vectors_done = 0;
  int                          pairs_checked = 0;
  int                          keep_writes = 0;

  residual_topk_sparsifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // absolute value as unsigned, so the most negative residual ranks as 2^31
  function automatic logic [DATA_W-1:0] magnitude_of(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // add one element into its residual, rank it, and on the last element
  // of a vector release the top pairs as expectations
  function automatic void accumulate_and_rank(input element_t e);
    longint                   sum;
    logic signed [DATA_W-1:0] acc;
    logic [DATA_W-1:0]        mag;
    int                       p;
    int                       j;
    int                       k;
    int                       n;
    pair_t                    pr;
    sum = longint'(residual_mirror[next_slot]) + longint'(e.value);
    if (sum > SUM_MAX) begin
      acc = 32'sh7FFF_FFFF;
    end else if (sum < SUM_MIN) begin
      acc = 32'sh8000_0000;
    end else begin
      acc = sum[DATA_W-1:0];
    end
    residual_mirror[next_slot] = acc;

    // equal magnitude stays behind the earlier arrival
    mag = magnitude_of(acc);
    p = 0;
    while (p < ranked_count && magnitude_of(ranked_val[p]) >= mag) p++;
    if (p < MAX_KEEP) begin
      j = (ranked_count < MAX_KEEP) ? ranked_count : MAX_KEEP - 1;
      while (j > p) begin
        ranked_pos[j] = ranked_pos[j-1];
        ranked_val[j] = ranked_val[j-1];
        j--;
      end
      ranked_pos[p] = next_slot;
      ranked_val[p] = acc;
      if (ranked_count < MAX_KEEP) ranked_count++;
    end

    if (!e.last) begin
      next_slot++;  // wraps at the end of the residual memory
      return;
    end

    // K of 0 acts as 1, anything above the list size as the list size
    k = int'(keep_setting);
    if (k < 1) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    n = (ranked_count < k) ? ranked_count : k;
    for (j = 0; j < n; j++) begin
      pr.index = ranked_pos[j];
      pr.value = ranked_val[j];
      pr.last = (j == n - 1);
      pending_pairs.push_back(pr);
    end
    next_slot = '0;
    ranked_count = 0;
    vectors_done++;
  endfunction

  function automatic void queue_element(input logic signed [DATA_W-1:0] v, input logic l,
                                        input logic d);
    element_t e;
    e.value = v;
    e.last = l;
    e.wait_drain = d;
    element_queue.push_back(e);
  endfunction

  // mix of full-range, small (for ties) and extreme values
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: return int'($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // wait until all requests are taken and every pair is back, then let
  // the pipeline empty out
  task automatic settle();
    do @(posedge clk);
    while (element_queue.size() != 0 || in_valid || pending_pairs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write K through the config port, then read it back
  task automatic program_keep(input logic [CFG_W-1:0] k);
    // setup phase of the write, junk in the unused upper bits
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_KEEP_COUNT;
    cfg_pwdata <= ($urandom & ~32'h7F) | PDATA_W'(k);
    // access phase
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    keep_setting = k;
    keep_writes++;
    // back-to-back read: setup then access
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (cfg_prdata !== PDATA_W'(k))
      report_mismatch($sformatf("keep_count read %0d, wrote %0d", cfg_prdata, k));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // driver: present the next element request, hold it while stalled
  always @(posedge clk) begin : feed_elements
    logic go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // request taken at this edge
      if (in_valid) begin
        accumulate_and_rank(on_wire);
        elements_taken++;
      end
      go = element_queue.size() != 0 && (steady || $urandom_range(99) >= 34);
      // pressure: some vectors start only once the previous pairs are all back
      if (go && element_queue[0].wait_drain && pending_pairs.size() != 0) go = 1'b0;
      if (go) begin
        on_wire = element_queue.pop_front();
        in_sample_value <= on_wire.value;
        in_last_element <= on_wire.last;
      end
      in_valid <= go;
    end
  end

  // monitor: check each accepted pair against the oldest expectation
  always @(posedge clk) begin : watch_pairs
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("pair with none expected: index %0d value %0d",
                                  out_entry_index, out_entry_value));
      end else begin
        want = pending_pairs.pop_front();
        if (out_entry_index !== want.index)
          report_mismatch($sformatf("entry_index %0d, expected %0d",
                                    out_entry_index, want.index));
        if (out_entry_value !== want.value)
          report_mismatch($sformatf("entry_value %0d, expected %0d",
                                    out_entry_value, want.value));
        if (out_last_entry !== want.last)
          report_mismatch($sformatf("last_entry %0b, expected %0b",
                                    out_last_entry, want.last));
        pairs_checked++;
      end
    end
    // random backpressure on the result side
    out_stall <= !steady && ($urandom_range(99) < 34);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pairs still expected",
               cycle_count, pending_pairs.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int                       i;
    int                       j;
    int                       len;
    int                       random_items;
    logic [CFG_W-1:0]         kv;

    for (i = 0; i < VECTOR_DEPTH; i++) residual_mirror[i] = '0;
    next_slot = '0;
    ranked_count = 0;
    keep_setting = KEEP_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset K of 8: both 32-bit extremes, equal magnitudes of both signs,
    // nine elements so the smallest one is left out
    queue_element(32'sh7FFF_FFFF, 1'b0, 1'b0);
    queue_element(32'sh8000_0000, 1'b0, 1'b0);
    queue_element(5, 1'b0, 1'b0);
    queue_element(-5, 1'b0, 1'b0);
    queue_element(5, 1'b0, 1'b0);
    queue_element(0, 1'b0, 1'b0);
    queue_element(-1, 1'b0, 1'b0);
    queue_element(1, 1'b0, 1'b0);
    queue_element(3, 1'b1, 1'b0);
    // short vector on the same positions: saturation up and down, cancel to 0
    queue_element(32'sh7FFF_FFFF, 1'b0, 1'b1);
    queue_element(32'sh8000_0000, 1'b0, 1'b0);
    queue_element(-5, 1'b1, 1'b0);
    settle();

    // smallest K
    program_keep(7'd1);
    queue_element(1, 1'b0, 1'b0);
    queue_element(32'sh7FFF_FFFF, 1'b1, 1'b0);
    settle();

    // K of zero acts as one; single-element vector
    program_keep(7'd0);
    queue_element(-7, 1'b1, 1'b0);
    settle();

    // K changed in the middle of a vector: the value at the last element counts
    program_keep(7'd64);
    queue_element(-9, 1'b0, 1'b0);
    queue_element(9, 1'b0, 1'b0);
    queue_element(32'sh8000_0000, 1'b0, 1'b0);
    settle();
    program_keep(7'd2);
    queue_element(2, 1'b0, 1'b0);
    queue_element(-100, 1'b1, 1'b0);
    settle();

    // largest K written, above the list size; a vector longer than the list,
    // sent with no idling on either side
    program_keep(7'd127);
    steady <= 1'b1;
    for (j = 0; j < 66; j++) queue_element(pick_value(), j == 65, 1'b0);
    settle();
    steady <= 1'b0;

    // random short vectors, now and then a new K between them
    random_items = 0;
    while (random_items < 16) begin
      if ($urandom_range(3) == 0) begin
        settle();
        case ($urandom_range(5))
          0: kv = 7'd0;
          1: kv = 7'd1;
          2: kv = 7'd64;
          3: kv = 7'd127;
          default: kv = CFG_W'($urandom_range(127));
        endcase
        program_keep(kv);
      end
      // keep the queue short so the vectors stay apart in time
      while (element_queue.size() > 4) @(posedge clk);
      len = $urandom_range(10, 1);
      for (j = 0; j < len; j++)
        queue_element(pick_value(), j == len - 1, j == 0 && $urandom_range(4) == 0);
      random_items += len;
    end

    settle();
    repeat (16) @(posedge clk);
    if (pending_pairs.size() != 0)
      report_mismatch($sformatf("%0d pairs never arrived", pending_pairs.size()));

    $display("run: %0d elements in %0d vectors, %0d pairs compared",
             elements_taken, vectors_done, pairs_checked);
    $display("run: %0d keep_count writes incl. 0, 1, 64, 127 and a change mid-vector",
             keep_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
